[rtl/sse_pkg.sv]
// Shared types and constants for the sorted set engine.
`timescale 1ns / 1ps

package sse_pkg;

	localparam int CMD_W       = 2;
	localparam int ENTRY_W     = 32;
	localparam int COUNT_OUT_W = 5;

	// Request command codes; the unused code acts as a query.
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

	// Step commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the request
		logic eval;    // register the per-cell compares
		logic apply;   // shift the cells and update the count
		logic finish;  // load the result register
	} ctrl_cmd_t;

endpackage

[rtl/sse_ctrl.sv]
// Controller state machine that steps one request through the datapath.
`timescale 1ns / 1ps

module sse_ctrl
	import sse_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output ctrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_APPLY,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	// The result register can take a new result when empty or being drained.
	assign slot_free = !out_valid_q || !out_stall;

	// Step commands decoded from the state.
	always_comb begin
		cmd.load   = (state_q == ST_IDLE) && in_valid;
		cmd.eval   = (state_q == ST_EVAL);
		cmd.apply  = (state_q == ST_APPLY);
		cmd.finish = (state_q == ST_FINISH) && slot_free;
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// State and the result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/sse_datapath.sv]
// Row of compare-and-shift cells holding the sorted entries, plus result register.
`timescale 1ns / 1ps

module sse_datapath
	import sse_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ctrl_cmd_t                 cmd,
	input  logic [CMD_W-1:0]          command,
	input  logic signed [ENTRY_W-1:0] value,
	output logic                      was_present,
	output logic                      changed,
	output logic                      full_drop,
	output logic [COUNT_OUT_W-1:0]    entry_count,
	output logic                      is_empty_flag,
	output logic signed [ENTRY_W-1:0] smallest,
	output logic signed [ENTRY_W-1:0] largest
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic signed [ENTRY_W-1:0] ent_q [CAPACITY];
	logic signed [ENTRY_W-1:0] ent_nxt [CAPACITY];
	logic [CNT_W-1:0]          count_q;
	logic [CMD_W-1:0]          cmd_q;
	logic signed [ENTRY_W-1:0] val_q;
	logic [CAPACITY-1:0]       lt_s1;
	logic [CAPACITY-1:0]       eq_s1;
	logic [CAPACITY-1:0]       lt_c;
	logic [CAPACITY-1:0]       eq_c;
	logic                      present;
	logic                      is_full;
	logic                      do_ins;
	logic                      do_rem;
	logic                      present_q;
	logic                      changed_q;
	logic                      drop_q;
	logic signed [ENTRY_W-1:0] top_entry;

	// Per-cell compares against the request value; cells past the count are ignored.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			lt_c[i] = (count_q > CNT_W'(i)) && (ent_q[i] < val_q);
			eq_c[i] = (count_q > CNT_W'(i)) && (ent_q[i] == val_q);
		end
	end

	// Decision for the request from the registered compares.
	assign present = |eq_s1;
	assign is_full = (count_q == CNT_W'(CAPACITY));
	assign do_ins  = (cmd_q == CMD_INSERT) && !present && !is_full;
	assign do_rem  = (cmd_q == CMD_REMOVE) && present;

	// Next value of each cell: keep below the insert point, otherwise shift.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [ENTRY_W-1:0] ins_val;
		logic signed [ENTRY_W-1:0] rem_val;
		if (i == 0) begin : g_first
			assign ins_val = val_q;
		end else begin : g_rest
			assign ins_val = lt_s1[i-1] ? val_q : ent_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign rem_val = ent_q[i];
		end else begin : g_inner
			assign rem_val = ent_q[i+1];
		end
		always_comb begin
			if (lt_s1[i]) begin
				ent_nxt[i] = ent_q[i];
			end else if (do_ins) begin
				ent_nxt[i] = ins_val;
			end else if (do_rem) begin
				ent_nxt[i] = rem_val;
			end else begin
				ent_nxt[i] = ent_q[i];
			end
		end
	end

	// Entry storage; unwritten cells are never read.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			val_q <= value;
		end
		if (cmd.eval) begin
			lt_s1 <= lt_c;
			eq_s1 <= eq_c;
		end
		if (cmd.apply) begin
			for (int i = 0; i < CAPACITY; i++) begin
				ent_q[i] <= ent_nxt[i];
			end
			present_q <= present;
			changed_q <= do_ins || do_rem;
			drop_q    <= (cmd_q == CMD_INSERT) && !present && is_full;
		end
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.apply) begin
			if (do_ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rem) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Select the highest occupied cell.
	always_comb begin
		top_entry = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (count_q == CNT_W'(i + 1)) top_entry = top_entry | ent_q[i];
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			was_present   <= present_q;
			changed       <= changed_q;
			full_drop     <= drop_q;
			entry_count   <= COUNT_OUT_W'(count_q);
			is_empty_flag <= (count_q == '0);
			smallest      <= (count_q == '0) ? '0 : ent_q[0];
			largest       <= top_entry;
		end
	end

endmodule

[rtl/sorted_set_engine.sv]
// The controller steps each request through capture, per-cell compare, cell shift
// and result load in turn, and takes no new request until the last one is done.
// A full result register holds the final step until the result is taken.
// Reset clears the entry count and all control state; entries stay unwritten.
// Top level of the sorted set engine.
`timescale 1ns / 1ps

module sorted_set_engine
	import sse_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [CMD_W-1:0]          command,
	input  logic signed [ENTRY_W-1:0] value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      was_present,
	output logic                      changed,
	output logic                      full_drop,
	output logic [COUNT_OUT_W-1:0]    entry_count,
	output logic                      is_empty_flag,
	output logic signed [ENTRY_W-1:0] smallest,
	output logic signed [ENTRY_W-1:0] largest
);

	ctrl_cmd_t ctl_cmd;

	sse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (ctl_cmd)
	);

	sse_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (ctl_cmd),
		.command       (command),
		.value         (value),
		.was_present   (was_present),
		.changed       (changed),
		.full_drop     (full_drop),
		.entry_count   (entry_count),
		.is_empty_flag (is_empty_flag),
		.smallest      (smallest),
		.largest       (largest)
	);

`ifndef NO_ASSERTIONS
	// An accepted request moves straight into the compare step.
	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (ctl_cmd.eval && in_stall))
		else $error("accepted request did not enter the compare step");

	// A request that changed the set cannot also have been dropped.
	a_change_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && changed) |-> !full_drop)
		else $error("result both changed the set and dropped the insert");

	// An empty set reports zero for both ends.
	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_empty_flag) |-> (smallest == '0 && largest == '0))
		else $error("empty set reported nonzero smallest or largest");

	// The result register loads only when it is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !ctl_cmd.finish)
		else $error("result overwritten while stalled");
`endif

endmodule
